// ===== rtl/core/uarq_pkg.sv =====
// ----------------------------------------------------------------------------
// uarq_pkg
// Shared types and constants for the uart receive event queue: event record,
// function codes and the request bundle between the core and the ring.
// ----------------------------------------------------------------------------
package uarq_pkg;

	// default number of ring entries
	localparam int QueueDepthDefault = 64;

	// fixed field widths
	localparam int WordW  = 9;
	localparam int CharW  = 8;
	localparam int CountW = 7;

	// item function codes
	typedef enum logic {
		FUNC_CAPTURE = 1'b0,
		FUNC_POP     = 1'b1
	} func_t;

	// one queued event
	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             data_ok;
		logic             brk;
		logic             frame;
		logic             parity;
		logic             idle;
	} ev_t;

	// request from the core to the ring for one item
	typedef struct packed {
		logic push;
		logic pop;
	} ring_req_t;

endpackage

// ===== rtl/core/uarq_classify.sv =====
// ----------------------------------------------------------------------------
// uarq_classify
// Turns captured receiver status flags and the data word into one event and
// computes the next receive interrupt enable.
// ----------------------------------------------------------------------------
module uarq_classify (
	input  logic                        rx_not_empty,
	input  logic                        frame_err,
	input  logic                        parity_err,
	input  logic                        idle,
	input  logic [uarq_pkg::WordW-1:0]  word,
	input  logic                        int_en_cur,
	output uarq_pkg::ev_t               ev,
	output logic                        ev_valid,
	output logic                        int_en_next
);

	logic word_zero;
	logic brk_det;

	// break is a framing error on an all-zero word
	assign word_zero = (word == '0);
	assign brk_det   = rx_not_empty && frame_err && word_zero;

	// event fields
	always_comb begin
		ev.ch      = rx_not_empty ? word[uarq_pkg::CharW-1:0] : '0;
		ev.brk     = brk_det;
		ev.parity  = rx_not_empty && parity_err;
		ev.frame   = rx_not_empty && ((frame_err && !word_zero) || parity_err);
		ev.data_ok = rx_not_empty && !brk_det && !parity_err;
		ev.idle    = idle;
	end

	assign ev_valid = rx_not_empty || idle;

	// idle sets the enable after any clearing by a break
	always_comb begin
		int_en_next = int_en_cur;
		if (brk_det) begin
			int_en_next = 1'b0;
		end
		if (idle) begin
			int_en_next = 1'b1;
		end
	end

endmodule

// ===== rtl/core/uarq_ring.sv =====
// ----------------------------------------------------------------------------
// uarq_ring
// Event ring with write and read indexes and a fill count. A push on a full
// ring overwrites the oldest entry and moves the read index along.
// ----------------------------------------------------------------------------
module uarq_ring #(
	parameter int QUEUE_DEPTH = uarq_pkg::QueueDepthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  uarq_pkg::ring_req_t                  req,
	input  uarq_pkg::ev_t                        wr_data,
	output uarq_pkg::ev_t                        rd_data_s2,
	output logic                                 pop_ok_s2,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

	localparam int IdxW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	uarq_pkg::ev_t  ring_mem_q [QUEUE_DEPTH];
	logic [IdxW-1:0] wr_q;
	logic [IdxW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] wr_inc;
	logic [IdxW-1:0] rd_inc;
	logic            full;
	logic            empty;
	logic            do_pop;

	// index wrap at the ring depth
	assign wr_inc = (wr_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_inc = (rd_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign full   = (cnt_q == CntW'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = req.pop && !empty;

	// ring storage, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (req.push) begin
			ring_mem_q[wr_q] <= wr_data;
		end
		if (do_pop) begin
			rd_data_s2 <= ring_mem_q[rd_q];
		end
	end

	// indexes and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			cnt_q     <= '0;
			pop_ok_s2 <= 1'b0;
		end else begin
			pop_ok_s2 <= do_pop;
			if (req.push) begin
				wr_q <= wr_inc;
				if (full) begin
					rd_q <= rd_inc;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (do_pop) begin
				rd_q  <= rd_inc;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign count = cnt_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QUEUE_DEPTH))
		else $error("ring count above depth");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.push && req.pop))
		else $error("push and pop in the same cycle");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && full) |=> (cnt_q == CntW'(QUEUE_DEPTH)) && (rd_q == wr_q))
		else $error("overwrite on full ring lost track of the read index");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(req.pop && empty) |=> !pop_ok_s2 && $stable(cnt_q) && $stable(rd_q))
		else $error("pop on empty ring changed state");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok_s2 |-> $past(req.pop) && ($past(cnt_q) != '0))
		else $error("pop reported without a held event");
`endif

endmodule

// ===== rtl/core/uart_rx_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// uart_rx_event_queue_core
// Receive event queue: captures are classified and pushed into the ring,
// pops return the oldest event, every request gives one strobed result.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     func, flag_rx_not_empty, flag_frame_err,
//                             flag_parity_err, flag_idle, rx_word
//  result    done (1 cycle)   pop_ok, ev_char, ev_has_data, ev_break,
//                             ev_frame_err, ev_parity_err, ev_idle,
//                             queued_count, rx_int_enabled
//
//  one request per cycle; busy is always low
//  done is registered behind the input register: the input register feeds
//  the ring, whose read port is registered; the result is taken at the next edge
//  reset: empty ring, indexes zero, receive interrupt enable set
//  ring contents are not cleared; the fill count keeps pops off stale entries
// ----------------------------------------------------------------------------
module uart_rx_event_queue_core #(
	parameter int QUEUE_DEPTH = uarq_pkg::QueueDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic                          flag_rx_not_empty,
	input  logic                          flag_frame_err,
	input  logic                          flag_parity_err,
	input  logic                          flag_idle,
	input  logic [uarq_pkg::WordW-1:0]    rx_word,
	output logic                          done,
	output logic                          pop_ok,
	output logic [uarq_pkg::CharW-1:0]    ev_char,
	output logic                          ev_has_data,
	output logic                          ev_break,
	output logic                          ev_frame_err,
	output logic                          ev_parity_err,
	output logic                          ev_idle,
	output logic [uarq_pkg::CountW-1:0]   queued_count,
	output logic                          rx_int_enabled
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic                          valid_s1;
	logic                          func_s1;
	logic                          rx_ne_s1;
	logic                          fe_s1;
	logic                          pe_s1;
	logic                          idle_s1;
	logic [uarq_pkg::WordW-1:0]    word_s1;
	logic                          done_s2;
	logic                          int_en_q;
	logic                          int_en_next;
	logic                          capture;
	uarq_pkg::ev_t                 ev;
	logic                          ev_valid;
	uarq_pkg::ring_req_t           req;
	uarq_pkg::ev_t                 rd_data_s2;
	logic                          pop_ok_s2;
	logic [CntW-1:0]               count;
	logic [CntW+uarq_pkg::CountW-1:0] count_ext;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1  <= func;
			rx_ne_s1 <= flag_rx_not_empty;
			fe_s1    <= flag_frame_err;
			pe_s1    <= flag_parity_err;
			idle_s1  <= flag_idle;
			word_s1  <= rx_word;
		end
	end

	// classify the captured status
	uarq_classify u_classify (
		.rx_not_empty (rx_ne_s1),
		.frame_err    (fe_s1),
		.parity_err   (pe_s1),
		.idle         (idle_s1),
		.word         (word_s1),
		.int_en_cur   (int_en_q),
		.ev           (ev),
		.ev_valid     (ev_valid),
		.int_en_next  (int_en_next)
	);

	// ring request for this item
	assign capture  = valid_s1 && (func_s1 == uarq_pkg::FUNC_CAPTURE);
	assign req.push = capture && ev_valid;
	assign req.pop  = valid_s1 && (func_s1 == uarq_pkg::FUNC_POP);

	uarq_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.wr_data    (ev),
		.rd_data_s2 (rd_data_s2),
		.pop_ok_s2  (pop_ok_s2),
		.count      (count)
	);

	// receive interrupt enable and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_en_q <= 1'b1;
			done_s2  <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
			if (capture) begin
				int_en_q <= int_en_next;
			end
		end
	end

	// result fields, event part zero unless a pop succeeded
	assign done          = done_s2;
	assign pop_ok        = pop_ok_s2;
	assign ev_char       = pop_ok_s2 ? rd_data_s2.ch : '0;
	assign ev_has_data   = pop_ok_s2 && rd_data_s2.data_ok;
	assign ev_break      = pop_ok_s2 && rd_data_s2.brk;
	assign ev_frame_err  = pop_ok_s2 && rd_data_s2.frame;
	assign ev_parity_err = pop_ok_s2 && rd_data_s2.parity;
	assign ev_idle       = pop_ok_s2 && rd_data_s2.idle;
	assign count_ext     = {{uarq_pkg::CountW{1'b0}}, count};
	assign queued_count  = count_ext[uarq_pkg::CountW-1:0];
	assign rx_int_enabled = int_en_q;

endmodule

// ===== sim/tb_uart_rx_event_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_event_queue_core
// Self-checking bench for the uart receive event queue core. Capture and pop
// requests go through a queue-fed driver with random idle cycles. A local
// model of the event ring predicts every strobed result, and the monitor
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_uart_rx_event_queue_core;

	localparam int Depth      = uarq_pkg::QueueDepthDefault;
	localparam int CycleLimit = 200000;
	localparam int RandItems  = 1300;

	// one capture or pop request
	typedef struct {
		uarq_pkg::func_t fn;
		logic            rx_ne;
		logic            frame_err;
		logic            parity_err;
		logic            idle;
		logic [8:0]      word;
		logic            drain_first;
	} req_t;

	// one strobed result, packed in port order
	typedef struct packed {
		logic                        pop_ok;
		logic [uarq_pkg::CharW-1:0]  ch;
		logic                        data_ok;
		logic                        brk;
		logic                        frame;
		logic                        parity;
		logic                        idle;
		logic [uarq_pkg::CountW-1:0] count;
		logic                        int_en;
	} result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic                        func = uarq_pkg::FUNC_CAPTURE;
	logic                        flag_rx_not_empty = 1'b0;
	logic                        flag_frame_err = 1'b0;
	logic                        flag_parity_err = 1'b0;
	logic                        flag_idle = 1'b0;
	logic [uarq_pkg::WordW-1:0]  rx_word = '0;
	logic                        done;
	logic                        pop_ok;
	logic [uarq_pkg::CharW-1:0]  ev_char;
	logic                        ev_has_data;
	logic                        ev_break;
	logic                        ev_frame_err;
	logic                        ev_parity_err;
	logic                        ev_idle;
	logic [uarq_pkg::CountW-1:0] queued_count;
	logic                        rx_int_enabled;

	req_t    todo_reqs[$];
	result_t due_results[$];
	req_t    cur_req;

	// model of the ring state
	uarq_pkg::ev_t ring_mdl [Depth];
	int   wr_mdl = 0;
	int   rd_mdl = 0;
	int   count_mdl = 0;
	logic int_en_mdl = 1'b1;

	int   n_fail = 0;
	int   n_taken = 0;
	int   n_results = 0;
	int   n_items = 0;
	int   n_cycles = 0;
	logic hold_next = 1'b0;

	uart_rx_event_queue_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.flag_rx_not_empty(flag_rx_not_empty),
		.flag_frame_err   (flag_frame_err),
		.flag_parity_err  (flag_parity_err),
		.flag_idle        (flag_idle),
		.rx_word          (rx_word),
		.done             (done),
		.pop_ok           (pop_ok),
		.ev_char          (ev_char),
		.ev_has_data      (ev_has_data),
		.ev_break         (ev_break),
		.ev_frame_err     (ev_frame_err),
		.ev_parity_err    (ev_parity_err),
		.ev_idle          (ev_idle),
		.queued_count     (queued_count),
		.rx_int_enabled   (rx_int_enabled)
	);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// update the ring model for one accepted request, queue its result
	task automatic track_request(input req_t r);
		uarq_pkg::ev_t ev;
		logic          ev_ok;
		result_t       res;
		res = '0;
		if (r.fn == uarq_pkg::FUNC_POP) begin
			if (count_mdl != 0) begin
				ev          = ring_mdl[rd_mdl];
				rd_mdl      = (rd_mdl + 1) % Depth;
				count_mdl   = count_mdl - 1;
				res.pop_ok  = 1'b1;
				res.ch      = ev.ch;
				res.data_ok = ev.data_ok;
				res.brk     = ev.brk;
				res.frame   = ev.frame;
				res.parity  = ev.parity;
				res.idle    = ev.idle;
			end
		end else begin
			ev    = '0;
			ev_ok = 1'b0;
			// character with its error marks
			if (r.rx_ne) begin
				ev.ch      = r.word[uarq_pkg::CharW-1:0];
				ev.data_ok = 1'b1;
				ev_ok      = 1'b1;
				if (r.frame_err) begin
					if (r.word == '0) begin
						ev.brk     = 1'b1;
						ev.data_ok = 1'b0;
						int_en_mdl = 1'b0;
					end else begin
						ev.frame = 1'b1;
					end
				end
				if (r.parity_err) begin
					ev.parity  = 1'b1;
					ev.frame   = 1'b1;
					ev.data_ok = 1'b0;
				end
			end
			// idle line re-enables after any break in the same request
			if (r.idle) begin
				ev.idle    = 1'b1;
				ev_ok      = 1'b1;
				int_en_mdl = 1'b1;
			end
			// push, overwriting the oldest when full
			if (ev_ok) begin
				ring_mdl[wr_mdl] = ev;
				wr_mdl           = (wr_mdl + 1) % Depth;
				if (count_mdl == Depth)
					rd_mdl = (rd_mdl + 1) % Depth;
				else
					count_mdl = count_mdl + 1;
			end
		end
		res.count  = uarq_pkg::CountW'(count_mdl);
		res.int_en = int_en_mdl;
		due_results.push_back(res);
	endtask

	task automatic add_req(input uarq_pkg::func_t fn, input logic ne, input logic fe,
			input logic pe, input logic idl, input logic [8:0] word);
		req_t r;
		r.fn          = fn;
		r.rx_ne       = ne;
		r.frame_err   = fe;
		r.parity_err  = pe;
		r.idle        = idl;
		r.word        = word;
		r.drain_first = hold_next;
		hold_next     = 1'b0;
		todo_reqs.push_back(r);
		n_items++;
	endtask

	// random capture; valid_only keeps it an event (data or idle)
	task automatic add_rand_capture(input logic valid_only);
		logic       ne;
		logic       idl;
		logic [8:0] word;
		ne   = ($urandom_range(99, 0) < 80);
		idl  = ($urandom_range(99, 0) < 25);
		word = ($urandom_range(3, 0) == 0) ? 9'h000 : 9'($urandom);
		if (valid_only && !ne && !idl)
			ne = 1'b1;
		add_req(uarq_pkg::FUNC_CAPTURE, ne, 1'($urandom), ($urandom_range(99, 0) < 30),
			idl, word);
	endtask

	// driver: request handshake, model update on acceptance
	always @(posedge clk) begin : drive_req
		logic go;
		if (arst_n) begin
			go = start;
			if (start && !busy) begin
				track_request(cur_req);
				n_taken++;
				go = 1'b0;
			end
			if (!go && todo_reqs.size() != 0) begin
				if (todo_reqs[0].drain_first && due_results.size() != 0) begin
					// hold off until every result is back
				end else if (!(n_taken >= 500 && n_taken < 800) &&
						$urandom_range(99, 0) < 32) begin
					// random idle cycle
				end else begin
					cur_req = todo_reqs.pop_front();
					go      = 1'b1;
					func              <= cur_req.fn;
					flag_rx_not_empty <= cur_req.rx_ne;
					flag_frame_err    <= cur_req.frame_err;
					flag_parity_err   <= cur_req.parity_err;
					flag_idle         <= cur_req.idle;
					rx_word           <= cur_req.word;
				end
			end
			start <= go;
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin : check_result
		result_t got;
		result_t exp;
		if (arst_n && done) begin
			got = {pop_ok, ev_char, ev_has_data, ev_break, ev_frame_err, ev_parity_err,
				ev_idle, queued_count, rx_int_enabled};
			if (due_results.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result at cycle %0d", n_cycles);
			end else begin
				exp = due_results.pop_front();
				if (got !== exp) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("result %0d mismatch", n_results);
						$display({"  exp ok=%b ch=%h data=%b brk=%b frm=%b par=%b",
							" idle=%b cnt=%0d ie=%b"},
							exp.pop_ok, exp.ch, exp.data_ok, exp.brk, exp.frame,
							exp.parity, exp.idle, exp.count, exp.int_en);
						$display({"  got ok=%b ch=%h data=%b brk=%b frm=%b par=%b",
							" idle=%b cnt=%0d ie=%b"},
							got.pop_ok, got.ch, got.data_ok, got.brk, got.frame,
							got.parity, got.idle, got.count, got.int_en);
					end
				end
			end
			n_results++;
		end
	end

	// run limit
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CycleLimit) begin
			$display("tb_uart_rx_event_queue_core failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int mode;
		int len;
		// directed: empty pop, every event kind, then drain past empty
		add_req(uarq_pkg::FUNC_POP,     1'b0, 1'b0, 1'b0, 1'b0, 9'h000);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b0, 1'b0, 1'b0, 9'h1A5);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b0, 1'b0, 1'b0, 9'h0FF);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b1, 1'b0, 1'b0, 9'h100);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b1, 1'b1, 1'b0, 9'h000);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b0, 1'b1, 1'b0, 9'h055);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b0, 1'b0, 1'b0, 1'b1, 9'h1C3);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b1, 1'b0, 1'b1, 9'h000);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b0, 1'b1, 1'b1, 1'b0, 9'h1FF);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b0, 1'b0, 1'b0, 1'b0, 9'h0AA);
		add_req(uarq_pkg::FUNC_CAPTURE, 1'b1, 1'b1, 1'b1, 1'b1, 9'h1FF);
		repeat (10)
			add_req(uarq_pkg::FUNC_POP, 1'b0, 1'b0, 1'b0, 1'b0, 9'h1FF);

		// random: fill bursts past full, drain runs and mixed traffic
		hold_next = 1'b1;
		while (n_items < RandItems + 22) begin
			mode = $urandom_range(3, 0);
			if ($urandom_range(5, 0) == 0)
				hold_next = 1'b1;
			case (mode)
				0: begin
					len = $urandom_range(90, 60);
					repeat (len)
						add_rand_capture(1'b1);
				end
				1: begin
					len = $urandom_range(70, 5);
					repeat (len)
						add_req(uarq_pkg::FUNC_POP, 1'($urandom), 1'($urandom),
							1'($urandom), 1'($urandom), 9'($urandom));
				end
				default: begin
					len = $urandom_range(60, 20);
					repeat (len) begin
						if ($urandom_range(1, 0) == 0)
							add_req(uarq_pkg::FUNC_POP, 1'b0, 1'b0, 1'b0, 1'b0,
								9'($urandom));
						else
							add_rand_capture(1'b0);
					end
				end
			endcase
		end

		// reset, then let the driver run
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all requests and results, then a short tail
		@(negedge clk);
		while (todo_reqs.size() != 0 || start)
			@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (n_fail == 0)
			$display("tb_uart_rx_event_queue_core passed");
		else
			$display("tb_uart_rx_event_queue_core failed");
		$finish;
	end

endmodule

// ===== uart_rx_event_queue_core.f =====
rtl/core/uarq_pkg.sv
rtl/core/uarq_classify.sv
rtl/core/uarq_ring.sv
rtl/core/uart_rx_event_queue_core.sv
sim/tb_uart_rx_event_queue_core.sv
